/* rtl/sfep_pkg.sv */
// ----------------------------------------------------------------------------
// sfep_pkg
// Shared constants and types for the SPI flash erase/program sequencer.
// ----------------------------------------------------------------------------
package sfep_pkg;

   localparam int BUF_DEPTH = 1024;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int PTR_W     = $clog2(BUF_DEPTH + 1);

   // flash opcodes
   localparam logic [7:0] OPC_WREN  = 8'h06;
   localparam logic [7:0] OPC_ERASE = 8'hC7;
   localparam logic [7:0] OPC_RDSR  = 8'h05;
   localparam logic [7:0] OPC_PP    = 8'h02;

   // item operations
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // sequencer phases
   localparam logic [3:0] PH_IDLE       = 4'd0;
   localparam logic [3:0] PH_ERASE_WREN = 4'd1;
   localparam logic [3:0] PH_ERASE_CMD  = 4'd2;
   localparam logic [3:0] PH_ERASE_POLL = 4'd3;
   localparam logic [3:0] PH_WAIT_BUF   = 4'd4;
   localparam logic [3:0] PH_PROG_WREN  = 4'd5;
   localparam logic [3:0] PH_PROG_CMD   = 4'd6;
   localparam logic [3:0] PH_ADDR       = 4'd7;
   localparam logic [3:0] PH_DATA       = 4'd8;
   localparam logic [3:0] PH_PROG_POLL  = 4'd9;

   // event codes
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_ERASED  = 2'd1;
   localparam logic [1:0] EV_WRITTEN = 2'd2;

   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
      logic [7:0]        data;
   } sfep_wr_type;

   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
   } sfep_rd_type;

endpackage

/* rtl/sfep_buffer.sv */
// ----------------------------------------------------------------------------
// sfep_buffer
// Page data buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfep_buffer (
   input  logic                 clock,
   input  sfep_pkg::sfep_wr_type wr,
   input  sfep_pkg::sfep_rd_type rd,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [sfep_pkg::BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/spi_flash_erase_program_sequencer.sv */
// ----------------------------------------------------------------------------
// spi_flash_erase_program_sequencer
// Steps a SPI NOR flash through chip erase and page program, one byte
// exchange per tick item, programming bytes loaded into an internal buffer.
// ----------------------------------------------------------------------------
// Each item's result is registered and valid in the cycle after acceptance.
// Throughput: one item per clock when not stalled; the buffer RAM read for a
// data byte is issued at acceptance and lands in the result register stage.
// Reset: synchronous; sequencer goes idle with chip select released and all
// counters cleared. The buffer RAM is not cleared.
module spi_flash_erase_program_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic       req_erase_first,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_rx_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_select_active,
   output logic [1:0] rsp_event_code,
   output logic       rsp_load_ok,
   output logic [3:0] rsp_phase
);

   localparam int AW = sfep_pkg::BUF_AW;
   localparam int PW = sfep_pkg::PTR_W;

   // sequencer state
   logic [3:0]    phase_ff, phase_in;
   logic          pend_ff, pend_in;
   logic          pstart_ff, pstart_in;
   logic          pcross_ff, pcross_in;
   logic          buf_free_ff, buf_free_in;
   logic          stat_seen_ff, stat_seen_in;
   logic [23:0]   addr_ff, addr_in;
   logic [1:0]    abl_ff, abl_in;
   logic [PW-1:0] sent_ff, sent_in;
   logic [PW-1:0] blen_ff, blen_in;
   logic [PW-1:0] lptr_ff, lptr_in;
   logic [15:0]   pages_ff, pages_in;
   logic          cs_ff, cs_in;

   // result stage
   logic          res_valid_ff, res_valid_in;
   logic          res_txv_ff;
   logic [7:0]    res_txb_ff;
   logic          res_mem_ff;
   logic [1:0]    res_ev_ff;
   logic          res_lok_ff;

   logic          accept;
   logic          txv;
   logic [7:0]    txb;
   logic          use_mem;
   logic [1:0]    ev;
   logic          lok;
   logic [7:0]    opc;
   logic [7:0]    rd_data;

   sfep_pkg::sfep_wr_type wr;
   sfep_pkg::sfep_rd_type rd;

   assign req_stall    = res_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign res_valid_in = accept | (res_valid_ff & rsp_stall);

   always_comb begin
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      pstart_in    = pstart_ff;
      pcross_in    = pcross_ff;
      buf_free_in  = buf_free_ff;
      stat_seen_in = stat_seen_ff;
      addr_in      = addr_ff;
      abl_in       = abl_ff;
      sent_in      = sent_ff;
      blen_in      = blen_ff;
      lptr_in      = lptr_ff;
      pages_in     = pages_ff;
      cs_in        = cs_ff;
      txv          = 1'b0;
      txb          = 8'd0;
      use_mem      = 1'b0;
      ev           = sfep_pkg::EV_NONE;
      lok          = 1'b0;
      opc          = sfep_pkg::OPC_PP;
      wr.en        = 1'b0;
      wr.addr      = lptr_ff[AW-1:0];
      wr.data      = req_data_byte;
      rd.en        = 1'b0;
      rd.addr      = sent_ff[AW-1:0];

      case (phase_ff)
         sfep_pkg::PH_ERASE_WREN, sfep_pkg::PH_PROG_WREN: opc = sfep_pkg::OPC_WREN;
         sfep_pkg::PH_ERASE_CMD:                          opc = sfep_pkg::OPC_ERASE;
         default:                                         opc = sfep_pkg::OPC_PP;
      endcase

      case (req_operation)
         sfep_pkg::OP_START, sfep_pkg::OP_STOP: begin
            pend_in      = (req_operation == sfep_pkg::OP_START);
            pstart_in    = 1'b1;
            pcross_in    = 1'b0;
            buf_free_in  = 1'b1;
            stat_seen_in = 1'b0;
            addr_in      = 24'd0;
            abl_in       = 2'd0;
            sent_in      = '0;
            blen_in      = '0;
            lptr_in      = '0;
            pages_in     = 16'd0;
            if (req_operation == sfep_pkg::OP_START) begin
               phase_in = req_erase_first ? sfep_pkg::PH_ERASE_WREN : sfep_pkg::PH_WAIT_BUF;
            end else begin
               cs_in    = 1'b0;
               phase_in = sfep_pkg::PH_IDLE;
            end
         end
         sfep_pkg::OP_LOAD: begin
            if (buf_free_ff && lptr_ff < PW'(sfep_pkg::BUF_DEPTH)) begin
               wr.en   = 1'b1;
               lptr_in = lptr_ff + PW'(1);
               lok     = 1'b1;
               if (req_last_byte) begin
                  blen_in     = lptr_ff + PW'(1);
                  lptr_in     = '0;
                  buf_free_in = 1'b0;
               end
            end
         end
         default: begin
            case (phase_ff)
               sfep_pkg::PH_ERASE_WREN, sfep_pkg::PH_ERASE_CMD,
               sfep_pkg::PH_PROG_WREN, sfep_pkg::PH_PROG_CMD: begin
                  if (pend_ff) begin
                     pend_in = 1'b0;
                     cs_in   = 1'b1;
                     txv     = 1'b1;
                     txb     = opc;
                  end else if (req_rx_ready) begin
                     pend_in = 1'b1;
                     if (phase_ff == sfep_pkg::PH_PROG_CMD) begin
                        abl_in   = 2'd3;
                        phase_in = sfep_pkg::PH_ADDR;
                     end else begin
                        cs_in    = 1'b0;
                        phase_in = phase_ff + 4'd1;
                     end
                  end
               end
               sfep_pkg::PH_ERASE_POLL, sfep_pkg::PH_PROG_POLL: begin
                  if (pend_ff) begin
                     pend_in      = 1'b0;
                     cs_in        = 1'b1;
                     stat_seen_in = 1'b0;
                     txv          = 1'b1;
                     txb          = sfep_pkg::OPC_RDSR;
                  end else if (req_rx_ready) begin
                     stat_seen_in = 1'b1;
                     if (stat_seen_ff && !req_rx_byte[0]) begin
                        cs_in = 1'b0;
                        if (phase_ff == sfep_pkg::PH_ERASE_POLL) begin
                           ev       = sfep_pkg::EV_ERASED;
                           phase_in = sfep_pkg::PH_WAIT_BUF;
                        end else begin
                           pend_in   = 1'b1;
                           pstart_in = 1'b1;
                           if (pcross_ff) begin
                              pages_in = pages_ff + 16'd1;
                              phase_in = sfep_pkg::PH_PROG_WREN;
                           end else begin
                              buf_free_in = 1'b1;
                              blen_in     = '0;
                              ev          = sfep_pkg::EV_WRITTEN;
                              phase_in    = sfep_pkg::PH_WAIT_BUF;
                           end
                        end
                     end else begin
                        // dummy byte clocks out the next status
                        txv = 1'b1;
                     end
                  end
               end
               sfep_pkg::PH_WAIT_BUF: begin
                  if (!buf_free_ff) begin
                     pend_in   = 1'b1;
                     pstart_in = 1'b1;
                     sent_in   = '0;
                     pages_in  = 16'd0;
                     phase_in  = sfep_pkg::PH_PROG_WREN;
                  end
               end
               sfep_pkg::PH_ADDR: begin
                  if (pend_ff || req_rx_ready) begin
                     if (abl_ff == 2'd0) begin
                        pend_in   = 1'b1;
                        pcross_in = 1'b0;
                        phase_in  = sfep_pkg::PH_DATA;
                     end else begin
                        pend_in = 1'b0;
                        txv     = 1'b1;
                        case (abl_ff)
                           2'd3:    txb = addr_ff[23:16];
                           2'd2:    txb = addr_ff[15:8];
                           default: txb = addr_ff[7:0];
                        endcase
                        abl_in = abl_ff - 2'd1;
                     end
                  end
               end
               sfep_pkg::PH_DATA: begin
                  if (pend_ff || req_rx_ready) begin
                     pend_in = 1'b0;
                     if (addr_ff[7:0] != 8'd0 || pstart_ff) begin
                        pstart_in = 1'b0;
                        if (sent_ff >= blen_ff) begin
                           pend_in  = 1'b1;
                           cs_in    = 1'b0;
                           phase_in = sfep_pkg::PH_PROG_POLL;
                        end else begin
                           // byte comes from the buffer RAM next cycle
                           txv     = 1'b1;
                           use_mem = 1'b1;
                           rd.en   = 1'b1;
                           addr_in = addr_ff + 24'd1;
                           sent_in = sent_ff + PW'(1);
                        end
                     end else begin
                        // page boundary: close the program command
                        cs_in     = 1'b0;
                        pend_in   = 1'b1;
                        pcross_in = 1'b1;
                        phase_in  = sfep_pkg::PH_PROG_POLL;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      endcase

      if (!accept) begin
         wr.en = 1'b0;
         rd.en = 1'b0;
      end
   end

   sfep_buffer u_buffer (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sfep_pkg::PH_IDLE;
         pend_ff      <= 1'b0;
         pstart_ff    <= 1'b1;
         pcross_ff    <= 1'b0;
         buf_free_ff  <= 1'b1;
         stat_seen_ff <= 1'b0;
         addr_ff      <= 24'd0;
         abl_ff       <= 2'd0;
         sent_ff      <= '0;
         blen_ff      <= '0;
         lptr_ff      <= '0;
         pages_ff     <= 16'd0;
         cs_ff        <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            pend_ff      <= pend_in;
            pstart_ff    <= pstart_in;
            pcross_ff    <= pcross_in;
            buf_free_ff  <= buf_free_in;
            stat_seen_ff <= stat_seen_in;
            addr_ff      <= addr_in;
            abl_ff       <= abl_in;
            sent_ff      <= sent_in;
            blen_ff      <= blen_in;
            lptr_ff      <= lptr_in;
            pages_ff     <= pages_in;
            cs_ff        <= cs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_txv_ff <= txv;
         res_txb_ff <= txb;
         res_mem_ff <= use_mem;
         res_ev_ff  <= ev;
         res_lok_ff <= lok;
      end
   end

   assign rsp_valid         = res_valid_ff;
   assign rsp_tx_valid      = res_txv_ff;
   assign rsp_tx_byte       = res_mem_ff ? rd_data : res_txb_ff;
   assign rsp_select_active = cs_ff;
   assign rsp_event_code    = res_ev_ff;
   assign rsp_load_ok       = res_lok_ff;
   assign rsp_phase         = phase_ff;

   a_lptr_range: assert property (@(posedge clock) disable iff (reset)
      lptr_ff <= PW'(sfep_pkg::BUF_DEPTH))
      else $error("load pointer beyond buffer depth");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= sfep_pkg::PH_PROG_POLL)
      else $error("unused phase code entered");

   a_committed_len: assert property (@(posedge clock) disable iff (reset)
      !buf_free_ff |-> blen_ff != '0)
      else $error("committed buffer with zero length");

   a_idle_cs: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sfep_pkg::PH_IDLE |-> !cs_ff)
      else $error("chip select active while idle");

   a_mem_tx: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_mem_ff |-> res_txv_ff && phase_ff == sfep_pkg::PH_DATA)
      else $error("buffer byte result outside data phase");

endmodule
